[hw/rtl/fwb_pkg.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwb_pkg
// Shared constants for the filter weight binarizer: defaults, register map,
// configuration field widths and reset values.
// ----------------------------------------------------------------------------
package fwb_pkg;

    localparam int DEF_MAX_FILTER_WEIGHTS = 64;
    localparam int DEF_WEIGHT_BITS        = 16;

    localparam int CFG_DATA_W = 32;
    localparam int CFG_ADDR_W = 3;

    localparam int WPF_W = 7;
    localparam int FC_W  = 13;
    localparam int FD_W  = 12;

    localparam logic [FC_W-1:0] MAX_FILTERS = 13'd4096;

    localparam logic REG_WEIGHTS_PER_FILTER = 1'b0;
    localparam logic REG_FILTER_COUNT       = 1'b1;

    localparam logic [WPF_W-1:0] WPF_RESET = 7'd9;
    localparam logic [FC_W-1:0]  FC_RESET  = 13'd1;

endpackage
`default_nettype wire

[hw/rtl/fwb_front.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwb_front
// Takes weight beats, records signs, sums magnitudes and hands one job per
// finished filter to the job queue.
// ----------------------------------------------------------------------------
module fwb_front #(
    parameter int MAX_FILTER_WEIGHTS = fwb_pkg::DEF_MAX_FILTER_WEIGHTS,
    parameter int WEIGHT_BITS        = fwb_pkg::DEF_WEIGHT_BITS,
    localparam int IDX_W = (MAX_FILTER_WEIGHTS > 1) ? $clog2(MAX_FILTER_WEIGHTS) : 1,
    localparam int CNT_W = $clog2(MAX_FILTER_WEIGHTS + 1),
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_FILTER_WEIGHTS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_push,
    output logic                               o_full,
    input  wire logic signed [WEIGHT_BITS-1:0] i_weight_value,
    input  wire logic [fwb_pkg::WPF_W-1:0]     i_wpf,
    input  wire logic [fwb_pkg::FC_W-1:0]      i_fc,
    input  wire logic                          i_q_full,
    output logic                               o_q_push,
    output logic [SUM_W-1:0]                   o_job_sum,
    output logic [CNT_W-1:0]                   o_job_count,
    output logic [MAX_FILTER_WEIGHTS-1:0]      o_job_signs,
    output logic                               o_job_last_layer
);

    logic [SUM_W-1:0]              r_sum, n_sum;
    logic [IDX_W-1:0]              r_seen, n_seen;
    logic [fwb_pkg::FD_W-1:0]      r_fd, n_fd;
    logic [MAX_FILTER_WEIGHTS-1:0] r_signs, n_signs;

    logic                          accept;
    logic                          negative;
    logic [WEIGHT_BITS-1:0]        magnitude;
    logic [CNT_W-1:0]              size;
    logic [fwb_pkg::FC_W-1:0]      total;
    logic [CNT_W-1:0]              count;
    logic [SUM_W-1:0]              sum_new;
    logic                          filter_end;
    logic                          last_layer;

    assign accept   = i_push && !i_q_full;
    assign o_full   = i_q_full;
    assign negative = i_weight_value[WEIGHT_BITS-1];
    assign magnitude = negative ? (~i_weight_value + 1'b1) : i_weight_value;

    always_comb begin
        priority if (i_wpf == '0) begin
            size = CNT_W'(1);
        end else if (i_wpf > fwb_pkg::WPF_W'(MAX_FILTER_WEIGHTS)) begin
            size = CNT_W'(MAX_FILTER_WEIGHTS);
        end else begin
            size = i_wpf[CNT_W-1:0];
        end
        priority if (i_fc == '0) begin
            total = fwb_pkg::FC_W'(1);
        end else if (i_fc > fwb_pkg::MAX_FILTERS) begin
            total = fwb_pkg::MAX_FILTERS;
        end else begin
            total = i_fc;
        end
    end

    assign count      = CNT_W'(r_seen) + CNT_W'(1);
    assign sum_new    = r_sum + SUM_W'(magnitude);
    assign filter_end = (count >= size);
    assign last_layer = ({1'b0, r_fd} + fwb_pkg::FC_W'(1)) >= total;

    always_comb begin
        n_signs = r_signs;
        n_sum   = r_sum;
        n_seen  = r_seen;
        n_fd    = r_fd;
        if (accept) begin
            n_signs[r_seen] = !negative && (i_weight_value != '0);
            if (filter_end) begin
                n_sum  = '0;
                n_seen = '0;
                n_fd   = last_layer ? '0 : (r_fd + 1'b1);
            end else begin
                n_sum  = sum_new;
                n_seen = count[IDX_W-1:0];
            end
        end
    end

    assign o_q_push         = accept && filter_end;
    assign o_job_sum        = sum_new;
    assign o_job_count      = count;
    assign o_job_signs      = n_signs;
    assign o_job_last_layer = last_layer;

    always_ff @(posedge i_clk) begin
        r_signs <= n_signs;
        if (!i_rst_n) begin
            r_sum  <= '0;
            r_seen <= '0;
            r_fd   <= '0;
        end else begin
            r_sum  <= n_sum;
            r_seen <= n_seen;
            r_fd   <= n_fd;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fwb_job_queue.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwb_job_queue
// Two-entry queue of finished filter jobs between front and back.
// ----------------------------------------------------------------------------
module fwb_job_queue #(
    parameter int DATA_W = 8
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_push,
    input  wire logic [DATA_W-1:0] i_data,
    output logic                   o_full,
    input  wire logic              i_pop,
    output logic [DATA_W-1:0]      o_data,
    output logic                   o_empty
);

    logic [DATA_W-1:0] r_mem [2];
    logic              r_wr_ptr, r_rd_ptr;
    logic [1:0]        r_fill;
    logic              do_push, do_pop;

    assign o_full  = (r_fill == 2'd2);
    assign o_empty = (r_fill == 2'd0);
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_fill   <= 2'd0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= ~r_wr_ptr;
            end
            if (do_pop) begin
                r_rd_ptr <= ~r_rd_ptr;
            end
            r_fill <= r_fill + 2'(do_push) - 2'(do_pop);
        end
    end

endmodule
`default_nettype wire

[hw/rtl/fwb_divider.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwb_divider
// Restoring divider, one quotient bit per cycle, for sum / weight count.
// ----------------------------------------------------------------------------
module fwb_divider #(
    parameter int NUM_W = 22,
    parameter int DEN_W = 7,
    localparam int STEP_W = $clog2(NUM_W + 1)
) (
    input  wire logic             i_clk,
    input  wire logic             i_rst_n,
    input  wire logic             i_start,
    input  wire logic [NUM_W-1:0] i_num,
    input  wire logic [DEN_W-1:0] i_den,
    output logic                  o_done,
    output logic [NUM_W-1:0]      o_quot
);

    logic [NUM_W-1:0]  r_num;
    logic [DEN_W-1:0]  r_den;
    logic [DEN_W-1:0]  r_rem;
    logic [STEP_W-1:0] r_step;
    logic              r_busy, r_done;
    logic [DEN_W:0]    trial;
    logic              qbit;

    assign trial = {r_rem, r_num[NUM_W-1]};
    assign qbit  = (trial >= {1'b0, r_den});

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num <= i_num;
            r_den <= i_den;
            r_rem <= '0;
        end else if (r_busy) begin
            r_num <= {r_num[NUM_W-2:0], qbit};
            r_rem <= qbit ? DEN_W'(trial - {1'b0, r_den}) : trial[DEN_W-1:0];
        end
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_step <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_step <= STEP_W'(NUM_W);
            end else if (r_busy) begin
                r_step <= r_step - 1'b1;
                if (r_step == STEP_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    assign o_done = r_done;
    assign o_quot = r_num;

endmodule
`default_nettype wire

[hw/rtl/fwb_back.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// fwb_back
// Takes one job at a time: divides for the mean, saturates, then emits one
// signed mean per weight into the output register.
// ----------------------------------------------------------------------------
module fwb_back #(
    parameter int MAX_FILTER_WEIGHTS = fwb_pkg::DEF_MAX_FILTER_WEIGHTS,
    parameter int WEIGHT_BITS        = fwb_pkg::DEF_WEIGHT_BITS,
    localparam int CNT_W = $clog2(MAX_FILTER_WEIGHTS + 1),
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_FILTER_WEIGHTS)
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_q_empty,
    output logic                               o_q_pop,
    input  wire logic [SUM_W-1:0]              i_job_sum,
    input  wire logic [CNT_W-1:0]              i_job_count,
    input  wire logic [MAX_FILTER_WEIGHTS-1:0] i_job_signs,
    input  wire logic                          i_job_last_layer,
    output logic                               o_empty,
    input  wire logic                          i_pop,
    output logic signed [WEIGHT_BITS-1:0]      o_binary_weight,
    output logic                               o_last_in_filter,
    output logic                               o_last_in_layer
);

    typedef enum logic [2:0] {
        S_IDLE = 3'b001,
        S_DIV  = 3'b010,
        S_EMIT = 3'b100
    } t_back_state;

    localparam logic [WEIGHT_BITS-1:0] MEAN_MAX = {1'b0, {(WEIGHT_BITS-1){1'b1}}};

    t_back_state                   r_state, n_state;
    logic [WEIGHT_BITS-1:0]        r_mean;
    logic [MAX_FILTER_WEIGHTS-1:0] r_signs;
    logic [CNT_W-1:0]              r_count, r_k;
    logic                          r_last_layer;
    logic                          r_out_valid;
    logic signed [WEIGHT_BITS-1:0] r_out_value;
    logic                          r_out_lf, r_out_ll;

    logic                          div_start, div_done;
    logic [SUM_W-1:0]              div_quot;
    logic [WEIGHT_BITS-1:0]        mean_sat;
    logic                          out_taken, out_load, emit_last;

    fwb_divider #(
        .NUM_W (SUM_W),
        .DEN_W (CNT_W)
    ) u_divider (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (i_job_sum),
        .i_den   (i_job_count),
        .o_done  (div_done),
        .o_quot  (div_quot)
    );

    assign mean_sat  = (|div_quot[SUM_W-1:WEIGHT_BITS-1]) ? MEAN_MAX
                                                          : div_quot[WEIGHT_BITS-1:0];
    assign out_taken = i_pop && r_out_valid;
    assign out_load  = (r_state == S_EMIT) && (!r_out_valid || out_taken);
    assign emit_last = (CNT_W'(r_k + 1'b1) == r_count);
    assign div_start = (r_state == S_IDLE) && !i_q_empty;
    assign o_q_pop   = (r_state == S_DIV) && div_done;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: if (!i_q_empty) n_state = S_DIV;
            S_DIV:  if (div_done) n_state = S_EMIT;
            S_EMIT: if (out_load && emit_last) n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_mean       <= mean_sat;
            r_signs      <= i_job_signs;
            r_count      <= i_job_count;
            r_last_layer <= i_job_last_layer;
            r_k          <= '0;
        end else if (out_load) begin
            r_signs <= r_signs >> 1;
            r_k     <= CNT_W'(r_k + 1'b1);
        end
        if (out_load) begin
            r_out_value <= r_signs[0] ? r_mean : (~r_mean + 1'b1);
            r_out_lf    <= emit_last;
            r_out_ll    <= emit_last && r_last_layer;
        end
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (out_taken) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_empty          = !r_out_valid;
    assign o_binary_weight  = r_out_value;
    assign o_last_in_filter = r_out_lf;
    assign o_last_in_layer  = r_out_ll;

endmodule
`default_nettype wire

[hw/rtl/filter_weight_binarizer_unit.sv]
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// filter_weight_binarizer_unit
// XNOR-Net style weight binarizer, Q4.12 fixed point.
//
// Weights enter as queue beats (push/full), one per cycle while the two-entry
// job queue has room. Each filter of weights_per_filter weights becomes one
// job: signs plus magnitude sum. Results leave as queue beats (empty/pop):
// +mean or -mean per weight in arrival order, with last-of-filter and
// last-of-layer flags. Registers sit on an APB port (0x0 weights_per_filter,
// 0x4 filter_count); they must be written only while the block is idle, which
// the block itself does not enforce. Per filter the back end starts the
// bit-serial divider for WEIGHT_BITS + log2(MAX_FILTER_WEIGHTS) quotient bits
// (22 by default), takes the saturated mean, then emits one result per cycle
// while the receiver keeps taking them.
// The front keeps taking the next filters' weights meanwhile. When the
// receiver stalls, the output register holds its beat and the back end waits;
// once both queue entries are full, full rises. Reset empties all queues,
// clears sums and counters and loads register defaults (9, 1).
// ----------------------------------------------------------------------------
module filter_weight_binarizer_unit #(
    parameter int MAX_FILTER_WEIGHTS = fwb_pkg::DEF_MAX_FILTER_WEIGHTS,
    parameter int WEIGHT_BITS        = fwb_pkg::DEF_WEIGHT_BITS
) (
    input  wire logic                               i_clk,
    input  wire logic                               i_rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire logic signed [WEIGHT_BITS-1:0]      i_weight_value,
    output logic                                    empty,
    input  wire logic                               pop,
    output logic signed [WEIGHT_BITS-1:0]           o_binary_weight,
    output logic                                    o_last_in_filter,
    output logic                                    o_last_in_layer,
    input  wire logic                               psel,
    input  wire logic                               penable,
    input  wire logic                               pwrite,
    input  wire logic [fwb_pkg::CFG_ADDR_W-1:0]     paddr,
    input  wire logic [fwb_pkg::CFG_DATA_W-1:0]     pwdata,
    output logic [fwb_pkg::CFG_DATA_W-1:0]          prdata,
    output logic                                    pready
);

    localparam int CNT_W = $clog2(MAX_FILTER_WEIGHTS + 1);
    localparam int SUM_W = WEIGHT_BITS + $clog2(MAX_FILTER_WEIGHTS);
    localparam int JOB_W = SUM_W + CNT_W + MAX_FILTER_WEIGHTS + 1;

    logic [fwb_pkg::WPF_W-1:0]     r_wpf;
    logic [fwb_pkg::FC_W-1:0]      r_fc;
    logic                          cfg_write;

    logic                          q_push, q_full, q_pop, q_empty;
    logic [SUM_W-1:0]              f_sum, b_sum;
    logic [CNT_W-1:0]              f_count, b_count;
    logic [MAX_FILTER_WEIGHTS-1:0] f_signs, b_signs;
    logic                          f_last, b_last;
    logic [JOB_W-1:0]              q_in, q_out;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wpf <= fwb_pkg::WPF_RESET;
            r_fc  <= fwb_pkg::FC_RESET;
        end else if (cfg_write) begin
            unique case (paddr[2])
                fwb_pkg::REG_WEIGHTS_PER_FILTER: r_wpf <= pwdata[fwb_pkg::WPF_W-1:0];
                fwb_pkg::REG_FILTER_COUNT:       r_fc  <= pwdata[fwb_pkg::FC_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            fwb_pkg::REG_WEIGHTS_PER_FILTER: prdata = fwb_pkg::CFG_DATA_W'(r_wpf);
            fwb_pkg::REG_FILTER_COUNT:       prdata = fwb_pkg::CFG_DATA_W'(r_fc);
            default:                         prdata = '0;
        endcase
    end

    fwb_front #(
        .MAX_FILTER_WEIGHTS (MAX_FILTER_WEIGHTS),
        .WEIGHT_BITS        (WEIGHT_BITS)
    ) u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_weight_value   (i_weight_value),
        .i_wpf            (r_wpf),
        .i_fc             (r_fc),
        .i_q_full         (q_full),
        .o_q_push         (q_push),
        .o_job_sum        (f_sum),
        .o_job_count      (f_count),
        .o_job_signs      (f_signs),
        .o_job_last_layer (f_last)
    );

    assign q_in = {f_sum, f_count, f_signs, f_last};

    fwb_job_queue #(
        .DATA_W (JOB_W)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    assign {b_sum, b_count, b_signs, b_last} = q_out;

    fwb_back #(
        .MAX_FILTER_WEIGHTS (MAX_FILTER_WEIGHTS),
        .WEIGHT_BITS        (WEIGHT_BITS)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_q_empty        (q_empty),
        .o_q_pop          (q_pop),
        .i_job_sum        (b_sum),
        .i_job_count      (b_count),
        .i_job_signs      (b_signs),
        .i_job_last_layer (b_last),
        .o_empty          (empty),
        .i_pop            (pop),
        .o_binary_weight  (o_binary_weight),
        .o_last_in_filter (o_last_in_filter),
        .o_last_in_layer  (o_last_in_layer)
    );

endmodule
`default_nettype wire
